// ===== hdl/bia_pkg.sv =====
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, codes and controller/datapath interface types for the
// bitmap indexed block allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int DISK_BLOCKS     = 64;
    localparam int FILE_SLOTS      = 16;
    localparam int MAX_FILE_BLOCKS = 16;

    // fixed field widths
    localparam int MODE_W   = 1;
    localparam int FID_W    = 4;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 3;

    // derived widths
    localparam int BLK_W    = $clog2(DISK_BLOCKS);
    localparam int CNT_W    = $clog2(DISK_BLOCKS + 1);
    localparam int SLOT_W   = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int GOT_W    = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int RAM_DEPTH = FILE_SLOTS * MAX_FILE_BLOCKS;
    localparam int RAM_AW   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam logic MODE_CREATE = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EXISTS   = 3'd1,
        STAT_NOSPACE  = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_BADLEN   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DEL_RD,
        S_DEL_FREE,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic    load_req;
        logic    start_create;
        logic    start_delete;
        logic    scan_take;
        logic    scan_skip;
        logic    del_read;
        logic    del_free;
        logic    del_commit;
        logic    reply;
        status_t reply_status;
    } bia_cmd_t;

    typedef struct packed {
        logic is_delete;
        logic slot_bad;
        logic slot_used;
        logic len_bad;
        logic no_space;
        logic blk_free;
        logic take_last;
        logic walk_done;
        logic out_ready;
    } bia_sts_t;

endpackage

// ===== hdl/bitmap_indexed_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_indexed_block_allocator
// Indexed block allocator over a free-block bitmap with a per-file index list.
// ----------------------------------------------------------------------------
// One request is in work at a time. A rejected request passes from accept
// through the decide and reply states to its single result beat. A create
// scans the bitmap one block per cycle from block 0 while the result register
// can load, and emits a beat for each free block it takes. A delete walks the
// file's index list through the single read port of the index memory, whose
// read is registered, alternating a read state and a free state for each
// block. The bitmap and directory are flip-flops that reset marks all free
// and unused, so the block is ready right after reset; the index memory needs
// no clearing. A result register sits between the allocator and the result
// channel.
module bitmap_indexed_block_allocator
    import bia_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [FID_W-1:0]    file_id,
    input  logic [LEN_W-1:0]    length,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [BLK_W-1:0]    block_index,
    output logic [CNT_W-1:0]    free_count,
    output logic                last
);

    bia_cmd_t cmd;
    bia_sts_t sts;

    bia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bia_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .file_id     (file_id),
        .length      (length),
        .cmd         (cmd),
        .sts         (sts),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .block_index (block_index),
        .free_count  (free_count),
        .last        (last)
    );

    // a refusal is always a single final beat with no block
    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STAT_OK) |-> last && (block_index == '0))
        else $error("rejection beat not final or carries a block");

    // a block is only taken when it is free and the result register can load
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_take |-> sts.blk_free && sts.out_ready)
        else $error("scan took a used block or overwrote a pending beat");

    // free count never exceeds the disk size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(free_count) <= DISK_BLOCKS))
        else $error("free count out of range");

    // no new request is taken while a scan or walk is running
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_take || cmd.scan_skip || cmd.del_read || cmd.del_free |-> req_stall)
        else $error("request channel open during allocation work");

endmodule

// ===== hdl/bia_ram.sv =====
// ----------------------------------------------------------------------------
// bia_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bia_ctrl.sv =====
// ----------------------------------------------------------------------------
// bia_ctrl
// Request sequencer: checks a request, runs the bitmap scan for a create or
// the index list walk for a delete, and replies to a reject or a delete.
// ----------------------------------------------------------------------------
module bia_ctrl
    import bia_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  bia_sts_t sts,
    output bia_cmd_t cmd
);

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_REPLY;
                if (sts.slot_bad)
                begin
                    code_next = STAT_NOTFOUND;
                end
                else if (sts.is_delete)
                begin
                    if (!sts.slot_used)
                    begin
                        code_next = STAT_NOTFOUND;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
                else if (sts.slot_used)
                begin
                    code_next = STAT_EXISTS;
                end
                else if (sts.len_bad)
                begin
                    code_next = STAT_BADLEN;
                end
                else if (sts.no_space)
                begin
                    code_next = STAT_NOSPACE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.blk_free && sts.out_ready && sts.take_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DEL_RD:
            begin
                if (sts.walk_done)
                begin
                    code_next  = STAT_OK;
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = S_DEL_FREE;
                end
            end
            S_DEL_FREE:
            begin
                state_next = S_DEL_RD;
            end
            S_REPLY:
            begin
                if (sts.out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd              = '0;
        cmd.reply_status = code_reg;
        req_stall        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall    = 1'b0;
                cmd.load_req = req_valid;
            end
            S_DECIDE:
            begin
                if (!sts.slot_bad && sts.is_delete && sts.slot_used)
                begin
                    cmd.start_delete = 1'b1;
                end
                if (!sts.slot_bad && !sts.is_delete && !sts.slot_used
                    && !sts.len_bad && !sts.no_space)
                begin
                    cmd.start_create = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_take = sts.blk_free && sts.out_ready;
                cmd.scan_skip = !sts.blk_free;
            end
            S_DEL_RD:
            begin
                cmd.del_commit = sts.walk_done;
                cmd.del_read   = !sts.walk_done;
            end
            S_DEL_FREE:
            begin
                cmd.del_free = 1'b1;
            end
            S_REPLY:
            begin
                cmd.reply = sts.out_ready;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/bia_dp.sv =====
// ----------------------------------------------------------------------------
// bia_dp
// Allocator datapath: free-block bitmap, free count, directory, index list
// memory, scan and walk counters, and the result register.
// ----------------------------------------------------------------------------
module bia_dp
    import bia_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [MODE_W-1:0]   mode,
    input  logic [FID_W-1:0]    file_id,
    input  logic [LEN_W-1:0]    length,
    input  bia_cmd_t            cmd,
    output bia_sts_t            sts,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [BLK_W-1:0]    block_index,
    output logic [CNT_W-1:0]    free_count,
    output logic                last
);

    // request
    logic [MODE_W-1:0] mode_reg;
    logic [FID_W-1:0]  fid_reg;
    logic [LEN_W-1:0]  len_reg;

    // allocation state
    logic [DISK_BLOCKS-1:0] free_map_reg, free_map_next;
    logic [CNT_W-1:0]       free_total_reg, free_total_next;
    logic [FILE_SLOTS-1:0]  slot_used_reg, slot_used_next;
    logic [LEN_W-1:0]       slot_len_reg [FILE_SLOTS];
    logic [LEN_W-1:0]       slot_len_next [FILE_SLOTS];

    // sequencing counters
    logic [BLK_W-1:0] scan_reg, scan_next;
    logic [GOT_W-1:0] got_reg, got_next;
    logic [GOT_W-1:0] walk_reg, walk_next;

    // result register
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [BLK_W-1:0]    block_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                last_reg;

    logic [SLOT_W-1:0] sidx;
    logic [RAM_AW-1:0] base;
    logic [BLK_W-1:0]  ram_rdata;
    logic              out_ready;

    assign sidx      = SLOT_W'(fid_reg);
    assign base      = RAM_AW'(32'(sidx) * MAX_FILE_BLOCKS);
    assign out_ready = !rsp_valid_reg || !rsp_stall;

    bia_ram #(
        .WIDTH (BLK_W),
        .DEPTH (RAM_DEPTH)
    ) u_list_ram (
        .clk   (clk),
        .we    (cmd.scan_take),
        .waddr (base + RAM_AW'(got_reg)),
        .wdata (scan_reg),
        .re    (cmd.del_read),
        .raddr (base + RAM_AW'(walk_reg)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.is_delete = (mode_reg == MODE_DELETE);
        sts.slot_bad  = (32'(fid_reg) >= FILE_SLOTS);
        sts.slot_used = slot_used_reg[sidx];
        sts.len_bad   = (len_reg == '0) || (32'(len_reg) > MAX_FILE_BLOCKS);
        sts.no_space  = (32'(len_reg) > 32'(free_total_reg));
        sts.blk_free  = free_map_reg[scan_reg];
        sts.take_last = ((32'(got_reg) + 1) == 32'(len_reg));
        sts.walk_done = (32'(walk_reg) == 32'(slot_len_reg[sidx]));
        sts.out_ready = out_ready;
    end

    always_comb
    begin
        free_map_next   = free_map_reg;
        free_total_next = free_total_reg;
        slot_used_next  = slot_used_reg;
        slot_len_next   = slot_len_reg;
        scan_next       = scan_reg;
        got_next        = got_reg;
        walk_next       = walk_reg;

        // the count is taken up front: the check already guarantees enough free blocks
        if (cmd.start_create)
        begin
            free_total_next      = free_total_reg - CNT_W'(len_reg);
            slot_used_next[sidx] = 1'b1;
            slot_len_next[sidx]  = len_reg;
            scan_next            = '0;
            got_next             = '0;
        end
        if (cmd.start_delete)
        begin
            walk_next = '0;
        end
        if (cmd.scan_take)
        begin
            free_map_next[scan_reg] = 1'b0;
            got_next                = got_reg + 1'b1;
            scan_next               = scan_reg + 1'b1;
        end
        if (cmd.scan_skip)
        begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.del_free)
        begin
            walk_next = walk_reg + 1'b1;
            if ((32'(ram_rdata) < DISK_BLOCKS) && !free_map_reg[ram_rdata])
            begin
                free_map_next[ram_rdata] = 1'b1;
                free_total_next          = free_total_reg + 1'b1;
            end
        end
        if (cmd.del_commit)
        begin
            slot_used_next[sidx] = 1'b0;
            slot_len_next[sidx]  = '0;
        end
    end

    assign rsp_valid_next = (cmd.scan_take || cmd.reply) ? 1'b1 :
                            (rsp_stall ? rsp_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg   <= '1;
            free_total_reg <= CNT_W'(DISK_BLOCKS);
            slot_used_reg  <= '0;
            for (int i = 0; i < FILE_SLOTS; i++)
            begin
                slot_len_reg[i] <= '0;
            end
            scan_reg       <= '0;
            got_reg        <= '0;
            walk_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            free_map_reg   <= free_map_next;
            free_total_reg <= free_total_next;
            slot_used_reg  <= slot_used_next;
            slot_len_reg   <= slot_len_next;
            scan_reg       <= scan_next;
            got_reg        <= got_next;
            walk_reg       <= walk_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= mode;
            fid_reg  <= file_id;
            len_reg  <= length;
        end
        if (cmd.scan_take)
        begin
            status_reg <= STAT_OK;
            block_reg  <= scan_reg;
            count_reg  <= free_total_reg;
            last_reg   <= sts.take_last;
        end
        else if (cmd.reply)
        begin
            status_reg <= cmd.reply_status;
            block_reg  <= '0;
            count_reg  <= free_total_reg;
            last_reg   <= 1'b1;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign block_index = block_reg;
    assign free_count  = count_reg;
    assign last        = last_reg;

endmodule
